/* sv/pba_pkg.sv */
// ----------------------------------------------------------------------------
// pba_pkg: shared types and constants for the page bitmap allocator
// Sizes of the page map, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int MAX_PAGES   = 1024;
	localparam int PAGE_W      = 10;
	localparam int CNT_W       = 11;
	localparam int WORD_W      = 64;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int NUM_WORDS   = MAX_PAGES / WORD_W;
	localparam int WORD_IDX_W  = PAGE_W - BIT_W;
	localparam int CNT_HI_W    = CNT_W - BIT_W;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK           = 2'd0,
		STAT_FULL         = 2'd1,
		STAT_NOT_FREEABLE = 2'd2
	} status_t;

	typedef enum logic {
		CFG_PAGE_COUNT = 1'b0,
		CFG_RESERVED   = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_FREE_CHK,
		ST_RESP
	} state_t;

	// one map word and the page window [lo, hi) it is searched in
	typedef struct packed {
		logic [WORD_IDX_W-1:0] word;
		logic [WORD_W-1:0]     used;
		logic [CNT_W-1:0]      lo;
		logic [CNT_W-1:0]      hi;
	} wc_query_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] bit_idx;
	} wc_result_t;

endpackage

/* sv/pba_ram.sv */
// ----------------------------------------------------------------------------
// pba_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/pba_word_check.sv */
// ----------------------------------------------------------------------------
// pba_word_check: free-page search over one map word
// Masks the word to the page window [lo, hi) and finds the lowest clear bit.
// ----------------------------------------------------------------------------
module pba_word_check import pba_pkg::*; (
	input  wc_query_t  query,
	output wc_result_t result
);

	logic [CNT_HI_W-1:0] word_x;
	logic [CNT_HI_W-1:0] lo_word;
	logic [CNT_HI_W-1:0] hi_word;
	logic [WORD_W-1:0]   cand;

	assign word_x  = {1'b0, query.word};
	assign lo_word = query.lo[CNT_W-1:BIT_W];
	assign hi_word = query.hi[CNT_W-1:BIT_W];

	// window mask per bit, from the word index and the low bits of the bounds
	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			cand[b] = !query.used[b]
				&& ((word_x > lo_word)
					|| (word_x == lo_word && BIT_W'(b) >= query.lo[BIT_W-1:0]))
				&& ((word_x < hi_word)
					|| (word_x == hi_word && BIT_W'(b) < query.hi[BIT_W-1:0]));
		end
	end

	// lowest candidate wins
	always_comb begin
		result.found   = 1'b0;
		result.bit_idx = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				result.found   = 1'b1;
				result.bit_idx = BIT_W'(b);
			end
		end
	end

endmodule

/* sv/page_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// page_bitmap_allocator_core: next-fit page allocator over a used-page bitmap
// Requests allocate or free one page; each request gives one response.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall, op, page): a request is taken when
// in_valid is high and in_stall low. in_stall is high from the cycle after a
// request is taken until its response has been loaded into the output register.
// Output channel (out_valid/out_stall, result_page, status): one response per
// request, held while out_stall is high. A new request may be taken while a
// response still waits; its own response waits for the output register.
// Config port (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is always
// high; index 0 is page_count, index 1 is reserved_pages. Write only when idle.
// The map is 16 words of 64 bits in a RAM with a registered read. An allocate
// scans word by word from the cursor word, one word per cycle through one
// mask-and-find unit, wrapping once: up to 17 word reads. An allocate passes
// through the start, scan and response states, a free through start, free
// check and response; the response state waits while the output register
// holds a stalled response. The next request is taken once back in idle.
// Reset clears the map through per-word valid bits, so no clearing pass is
// needed; the cursor goes to page 0, page_count to 1024 and reserved_pages to 1.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_core import pba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [PAGE_W-1:0] page,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PAGE_W-1:0] result_page,
	output logic [1:0]        status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [CNT_W-1:0]  cfg_data
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]      page_count_q;
	logic [CNT_W-1:0]      reserved_q;
	logic [PAGE_W-1:0]     cursor_q;

	logic                  op_q;
	logic [PAGE_W-1:0]     page_q;

	logic [CNT_W-1:0]      lim_q;
	logic [CNT_W-1:0]      p0_q;
	logic [CNT_W-1:0]      lo0_q;
	logic [WORD_IDX_W-1:0] last_word_q;

	logic [WORD_IDX_W-1:0] iss_word_q;
	logic                  iss_pass_q;
	logic                  iss_active_q;

	logic [WORD_IDX_W-1:0] chk_word_s1;
	logic                  chk_pass_s1;
	logic                  chk_vld_s1;
	logic                  row_vld_s1;

	logic [NUM_WORDS-1:0]  row_vld_q;

	logic [PAGE_W-1:0]     res_page_q;
	status_t               res_status_q;
	logic                  out_valid_q;
	logic [PAGE_W-1:0]     out_page_q;
	status_t               out_status_q;

	logic                  ram_we;
	logic [WORD_IDX_W-1:0] ram_waddr;
	logic [WORD_W-1:0]     ram_wdata;
	logic [WORD_IDX_W-1:0] ram_raddr;
	logic [WORD_W-1:0]     ram_rdata;
	logic [WORD_W-1:0]     rd_word;

	logic [CNT_W-1:0]      lim_c;
	logic [CNT_W-1:0]      lim_m1;
	logic [CNT_W-1:0]      p0_c;
	logic [CNT_W-1:0]      page_x;
	logic [CNT_W-1:0]      found_p1;
	logic [PAGE_W-1:0]     found_page;
	logic                  free_ok;
	logic                  scan_done;
	logic                  resp_load;
	logic                  in_take;

	wc_query_t             wc_q;
	wc_result_t            wc_r;

	pba_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pba_word_check u_check (
		.query  (wc_q),
		.result (wc_r)
	);

	assign cfg_ready   = 1'b1;
	assign in_stall    = (state_q != ST_IDLE);
	assign in_take     = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign result_page = out_page_q;
	assign status      = out_status_q;

	// pool limit and search start
	assign lim_c  = (page_count_q > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_count_q;
	assign lim_m1 = lim_c - CNT_W'(1);
	assign p0_c   = ({1'b0, cursor_q} < lim_c) ? {1'b0, cursor_q} : '0;

	// a word that was never written reads as all clear
	assign rd_word = ram_rdata & {WORD_W{row_vld_s1}};

	assign wc_q.word = chk_word_s1;
	assign wc_q.used = rd_word;
	assign wc_q.lo   = chk_pass_s1 ? reserved_q : lo0_q;
	assign wc_q.hi   = chk_pass_s1 ? p0_q : lim_q;

	assign found_page = {chk_word_s1, wc_r.bit_idx};
	assign found_p1   = {1'b0, found_page} + CNT_W'(1);
	assign scan_done  = chk_vld_s1 && (wc_r.found || !iss_active_q);

	assign page_x  = {1'b0, page_q};
	assign free_ok = (page_x < lim_q) && (page_x >= reserved_q)
		&& rd_word[page_q[BIT_W-1:0]];

	assign resp_load = (state_q == ST_RESP) && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = (op_q == OP_FREE) ? ST_FREE_CHK : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_RESP;
				end
			end
			ST_FREE_CHK: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (resp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// map port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = chk_word_s1;
		ram_wdata = rd_word;
		ram_raddr = iss_word_q;
		unique case (state_q)
			ST_START: begin
				ram_raddr = page_q[PAGE_W-1:BIT_W];
			end
			ST_SCAN: begin
				if (chk_vld_s1 && wc_r.found) begin
					ram_we    = 1'b1;
					ram_wdata = rd_word | (WORD_W'(1) << wc_r.bit_idx);
				end
			end
			ST_FREE_CHK: begin
				ram_waddr = page_q[PAGE_W-1:BIT_W];
				if (free_ok) begin
					ram_we    = 1'b1;
					ram_wdata = rd_word & ~(WORD_W'(1) << page_q[BIT_W-1:0]);
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			page_count_q <= CNT_W'(MAX_PAGES);
			reserved_q   <= CNT_W'(1);
			cursor_q     <= '0;
			row_vld_q    <= '0;
			iss_active_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_PAGE_COUNT) begin
					page_count_q <= cfg_data;
				end else begin
					reserved_q <= cfg_data;
				end
			end

			if (ram_we) begin
				row_vld_q[ram_waddr] <= 1'b1;
			end

			// issue side: walk the words, cursor word up to the last, then wrap
			chk_vld_s1 <= (state_q == ST_SCAN) && iss_active_q;
			if (state_q == ST_START) begin
				iss_active_q <= (op_q == OP_ALLOC);
			end else if (state_q == ST_SCAN && iss_active_q) begin
				if (!iss_pass_q && iss_word_q == last_word_q) begin
					iss_active_q <= (p0_q != '0);
				end else if (iss_pass_q && iss_word_q == p0_q[PAGE_W-1:BIT_W]) begin
					iss_active_q <= 1'b0;
				end
			end else if (state_q != ST_SCAN) begin
				iss_active_q <= 1'b0;
			end

			if (state_q == ST_SCAN && chk_vld_s1 && wc_r.found) begin
				cursor_q <= (found_p1 >= lim_q) ? '0 : found_p1[PAGE_W-1:0];
			end

			// hold a finished response until the output register frees up
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q   <= op;
			page_q <= page;
		end

		if (state_q == ST_START) begin
			lim_q       <= lim_c;
			p0_q        <= p0_c;
			lo0_q       <= (reserved_q > p0_c) ? reserved_q : p0_c;
			last_word_q <= (lim_c == '0) ? '0 : lim_m1[PAGE_W-1:BIT_W];
			iss_word_q  <= p0_c[PAGE_W-1:BIT_W];
			iss_pass_q  <= 1'b0;
		end else if (state_q == ST_SCAN && iss_active_q) begin
			if (!iss_pass_q && iss_word_q == last_word_q) begin
				iss_pass_q <= 1'b1;
				iss_word_q <= '0;
			end else begin
				iss_word_q <= iss_word_q + WORD_IDX_W'(1);
			end
		end

		chk_word_s1 <= iss_word_q;
		chk_pass_s1 <= iss_pass_q;
		row_vld_s1  <= row_vld_q[ram_raddr];

		if (state_q == ST_SCAN && scan_done) begin
			res_page_q   <= wc_r.found ? found_page : '0;
			res_status_q <= wc_r.found ? STAT_OK : STAT_FULL;
		end else if (state_q == ST_FREE_CHK) begin
			res_page_q   <= '0;
			res_status_q <= free_ok ? STAT_OK : STAT_NOT_FREEABLE;
		end

		if (resp_load) begin
			out_page_q   <= res_page_q;
			out_status_q <= res_status_q;
		end
	end

endmodule
